// ===== rtl/tile64x4_to_linear_address_generator_core_defines.svh =====
// Assertion macros shared by the detiling core.
`ifndef TILE64X4_TO_LINEAR_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define TILE64X4_TO_LINEAR_ADDRESS_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define T64DET_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define T64DET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/t64det_pkg.sv =====
// Shared constants, types and register codes for the 64x4 detiling core.
package t64det_pkg;

    // geometry
    localparam int unsigned TILE_W     = 64;
    localparam int unsigned SB         = 4;
    localparam int unsigned MAX_W      = 4096;
    localparam int unsigned MAX_H      = 4096;
    localparam int unsigned SB_PER_TILE = TILE_W / SB;

    // field widths
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned OFFSET_W  = 27;
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned TCOL_W    = 6;
    localparam int unsigned TROW_W    = 10;
    localparam int unsigned SBC_W     = 4;
    localparam int unsigned ROW_W     = 2;
    localparam int unsigned PLANE_W   = 2;
    localparam int unsigned TPR_W     = 7;
    localparam int unsigned TROWS_W   = 11;
    localparam int unsigned YW_W      = COORD_W + DIM_W;
    localparam int unsigned WH_W      = 2 * DIM_W;

    // request queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // chroma format codes
    localparam logic [1:0] FMT_NV12 = 2'd0;
    localparam logic [1:0] FMT_NV16 = 2'd1;
    localparam logic [1:0] FMT_I444 = 2'd2;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FORMAT = 2'd2,
        REG_WIDE   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [SAMPLE_W-1:0] out_sample_0;
        logic [SAMPLE_W-1:0] out_sample_1;
        logic [SAMPLE_W-1:0] out_sample_2;
        logic [SAMPLE_W-1:0] out_sample_3;
        logic                last_of_frame;
    } out_item_t;

    // effective frame setup derived from the registers
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [TPR_W-1:0]   tiles_per_row;
        logic [PLANE_W-1:0] plane_count;
        logic               half_chroma;
        logic               wide;
    } cfg_t;

    // one kept subblock row on its way to the offset pipeline
    typedef struct packed {
        logic [PLANE_W-1:0]  plane;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
        in_item_t            samples;
        logic                last;
        logic                wide;
    } qentry_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               full;
        logic               empty;
    } q_status_t;

    typedef struct packed {
        logic a_valid;
        logic a_stall;
    } back_status_t;

endpackage

// ===== rtl/t64det_if.sv =====
// Valid/ready stream interfaces for the tiled input and linear output.
interface t64det_in_if;
    logic                     valid;
    logic                     ready;
    t64det_pkg::in_item_t     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface t64det_out_if;
    logic                     valid;
    logic                     ready;
    t64det_pkg::out_item_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/t64det_front.sv =====
// Front end: position counters, row classification and request push.
module t64det_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  t64det_pkg::cfg_t       cfg,
    t64det_in_if.sink              tiled,
    input  t64det_pkg::q_status_t  q_status,
    output logic                   push,
    output t64det_pkg::qentry_t    push_entry
);

    localparam logic [t64det_pkg::SBC_W-1:0] SBC_LAST =
        t64det_pkg::SBC_W'(t64det_pkg::SB_PER_TILE - 1);

    logic [t64det_pkg::PLANE_W-1:0] plane_reg, plane_next;
    logic [t64det_pkg::TROW_W-1:0]  trow_reg, trow_next;
    logic [t64det_pkg::TCOL_W-1:0]  tcol_reg, tcol_next;
    logic [t64det_pkg::SBC_W-1:0]   sbc_reg, sbc_next;
    logic [t64det_pkg::ROW_W-1:0]   row_reg, row_next;

    logic                            stale;
    logic [t64det_pkg::PLANE_W-1:0] cur_plane;
    logic [t64det_pkg::TROW_W-1:0]  cur_trow;
    logic [t64det_pkg::TCOL_W-1:0]  cur_tcol;
    logic [t64det_pkg::SBC_W-1:0]   cur_sbc;
    logic [t64det_pkg::ROW_W-1:0]   cur_row;
    logic [t64det_pkg::DIM_W-1:0]   plane_h;
    logic [t64det_pkg::DIM_W-1:0]   plane_h_round;
    logic [t64det_pkg::TROWS_W-1:0] tile_rows;
    logic [t64det_pkg::COORD_W-1:0] y;
    logic [t64det_pkg::COORD_W-1:0] x;
    logic                            keep;
    logic                            last;
    logic                            accept;
    logic                            tcol_more;
    logic                            trow_more;
    logic [t64det_pkg::PLANE_W:0]   plane_inc;

    // a plane beyond the format's count starts a new frame
    always_comb
    begin
        stale     = (plane_reg >= cfg.plane_count);
        cur_plane = stale ? '0 : plane_reg;
        cur_trow  = stale ? '0 : trow_reg;
        cur_tcol  = stale ? '0 : tcol_reg;
        cur_sbc   = stale ? '0 : sbc_reg;
        cur_row   = stale ? '0 : row_reg;
    end

    // classify the row against the plane height
    always_comb
    begin
        plane_h       = (cur_plane != '0 && cfg.half_chroma) ? (cfg.height >> 1) : cfg.height;
        plane_h_round = plane_h + t64det_pkg::DIM_W'(3);
        tile_rows     = plane_h_round[t64det_pkg::DIM_W-1:2];
        y             = {cur_trow, cur_row};
        x             = {cur_tcol, cur_sbc, 2'b00};
        keep          = ({1'b0, y} < plane_h);
        last          = (cur_plane == cfg.plane_count - 2'd1)
                     && ({1'b0, cur_tcol} == cfg.tiles_per_row - t64det_pkg::TPR_W'(1))
                     && (cur_sbc == SBC_LAST)
                     && ({1'b0, y} == plane_h - t64det_pkg::DIM_W'(1));
    end

    // accept while the queue has room; drop rows past the plane height
    assign tiled.ready = !q_status.full;
    assign accept      = tiled.valid && tiled.ready;
    assign push        = accept && keep;

    always_comb
    begin
        push_entry.plane = cur_plane;
        push_entry.y     = y;
        push_entry.x     = x;
        push_entry.last  = last;
        push_entry.wide  = cfg.wide;
        if (cfg.wide)
        begin
            push_entry.samples = tiled.data;
        end
        else
        begin
            push_entry.samples.sample_0 = {8'h00, tiled.data.sample_0[7:0]};
            push_entry.samples.sample_1 = {8'h00, tiled.data.sample_1[7:0]};
            push_entry.samples.sample_2 = {8'h00, tiled.data.sample_2[7:0]};
            push_entry.samples.sample_3 = {8'h00, tiled.data.sample_3[7:0]};
        end
    end

    // advance: row, subblock, tile column, tile row, plane
    always_comb
    begin
        tcol_more  = ({1'b0, cur_tcol} + t64det_pkg::TPR_W'(1)) < cfg.tiles_per_row;
        trow_more  = ({1'b0, cur_trow} + t64det_pkg::TROWS_W'(1)) < tile_rows;
        plane_inc  = {1'b0, cur_plane} + (t64det_pkg::PLANE_W + 1)'(1);
        plane_next = plane_reg;
        trow_next  = trow_reg;
        tcol_next  = tcol_reg;
        sbc_next   = sbc_reg;
        row_next   = row_reg;
        if (accept)
        begin
            plane_next = cur_plane;
            trow_next  = cur_trow;
            tcol_next  = cur_tcol;
            sbc_next   = cur_sbc;
            row_next   = cur_row + 2'd1;
            if (cur_row == 2'd3)
            begin
                sbc_next = cur_sbc + 4'd1;
                if (cur_sbc == SBC_LAST)
                begin
                    tcol_next = tcol_more ? cur_tcol + 6'd1 : '0;
                    if (!tcol_more)
                    begin
                        trow_next = trow_more ? cur_trow + 10'd1 : '0;
                        if (!trow_more)
                        begin
                            plane_next = (plane_inc < {1'b0, cfg.plane_count})
                                       ? plane_inc[t64det_pkg::PLANE_W-1:0] : '0;
                        end
                    end
                end
            end
        end
    end

    // hold position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            trow_reg  <= '0;
            tcol_reg  <= '0;
            sbc_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
            trow_reg  <= trow_next;
            tcol_reg  <= tcol_next;
            sbc_reg   <= sbc_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ===== rtl/t64det_queue.sv =====
// Short request queue between the front end and the offset pipeline.
module t64det_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  t64det_pkg::qentry_t    push_entry,
    input  logic                   pop,
    output t64det_pkg::qentry_t    pop_entry,
    output t64det_pkg::q_status_t  status
);

    t64det_pkg::qentry_t mem_reg [t64det_pkg::FIFO_DEPTH];

    logic [t64det_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [t64det_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [t64det_pkg::FIFO_CW-1:0] count_reg, count_next;

    // status and head
    always_comb
    begin
        status.count = count_reg;
        status.full  = (count_reg == t64det_pkg::FIFO_CW'(t64det_pkg::FIFO_DEPTH));
        status.empty = (count_reg == '0);
        pop_entry    = mem_reg[rd_ptr_reg];
    end

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + t64det_pkg::FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + t64det_pkg::FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + t64det_pkg::FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - t64det_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/t64det_back.sv =====
// Back end: two-stage byte offset pipeline with an output register.
module t64det_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  t64det_pkg::cfg_t         cfg,
    input  t64det_pkg::q_status_t    q_status,
    input  t64det_pkg::qentry_t      head,
    output logic                     pop,
    t64det_out_if.source             linear,
    output t64det_pkg::back_status_t status
);

    // stage A: products
    logic                              a_valid_reg, a_valid_next;
    logic [t64det_pkg::YW_W-1:0]      a_yw_reg;
    logic [t64det_pkg::WH_W-1:0]      a_wh_reg;
    logic [t64det_pkg::PLANE_W-1:0]   a_plane_reg;
    logic [t64det_pkg::COORD_W-1:0]   a_x_reg;
    t64det_pkg::in_item_t              a_samples_reg;
    logic                              a_last_reg;
    logic                              a_wide_reg;

    // output register
    logic                              out_valid_reg, out_valid_next;
    t64det_pkg::out_item_t             out_item_reg, out_item_next;

    logic                              out_free;
    logic                              a_free;
    logic [t64det_pkg::OFFSET_W-1:0]  base;
    logic [t64det_pkg::OFFSET_W-1:0]  pix_offset;

    // stage handshakes
    assign out_free = !out_valid_reg || linear.ready;
    assign a_free   = !a_valid_reg || out_free;
    assign pop      = !q_status.empty && a_free;

    assign status.a_valid = a_valid_reg;
    assign status.a_stall = a_valid_reg && !out_free;

    assign linear.valid = out_valid_reg;
    assign linear.data  = out_item_reg;

    always_comb
    begin
        a_valid_next   = a_free ? pop : a_valid_reg;
        out_valid_next = out_free ? a_valid_reg : out_valid_reg;
    end

    // sum plane base, row start and column, then scale by sample size
    always_comb
    begin
        case (a_plane_reg)
            2'd1:    base = t64det_pkg::OFFSET_W'(a_wh_reg);
            2'd2:    base = t64det_pkg::OFFSET_W'({a_wh_reg, 1'b0});
            default: base = '0;
        endcase
        pix_offset = base + t64det_pkg::OFFSET_W'(a_yw_reg)
                   + t64det_pkg::OFFSET_W'(a_x_reg);
        out_item_next.byte_offset   = a_wide_reg
            ? {pix_offset[t64det_pkg::OFFSET_W-2:0], 1'b0} : pix_offset;
        out_item_next.out_sample_0  = a_samples_reg.sample_0;
        out_item_next.out_sample_1  = a_samples_reg.sample_1;
        out_item_next.out_sample_2  = a_samples_reg.sample_2;
        out_item_next.out_sample_3  = a_samples_reg.sample_3;
        out_item_next.last_of_frame = a_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // load stage A with the row and plane products
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_yw_reg      <= head.y * cfg.width;
            a_wh_reg      <= cfg.width * cfg.height;
            a_plane_reg   <= head.plane;
            a_x_reg       <= head.x;
            a_samples_reg <= head.samples;
            a_last_reg    <= head.last;
            a_wide_reg    <= head.wide;
        end
    end

    // load the output register
    always_ff @(posedge clk)
    begin
        if (out_free && a_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ===== rtl/tile64x4_to_linear_address_generator_core.sv =====
// Top level of the 64x4 tile to linear detiling address generator.
//
//   Channel   Dir   Handshake            Payload
//   tiled     in    valid/ready          sample_0..sample_3
//   linear    out   valid/ready          byte_offset, out_sample_0..3, last_of_frame
//   cfg       in    cfg_we               cfg_index, cfg_data
//
// One subblock row is accepted per cycle while the queue has room; a kept row
// passes the queue, product stage and output register before it is valid on linear.
// Rows past the plane height are accepted and give no result. A four-entry
// request queue absorbs output stalls; tiled.ready drops only when it is full.
// Reset clears all position counters and loads width 64, height 4, NV12,
// one-byte samples.
`include "tile64x4_to_linear_address_generator_core_defines.svh"

module tile64x4_to_linear_address_generator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    t64det_in_if.sink                          tiled,
    t64det_out_if.source                       linear,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [t64det_pkg::DIM_W-1:0]       cfg_data
);

    localparam logic [t64det_pkg::FIFO_CW-1:0] QUEUE_FULL =
        t64det_pkg::FIFO_CW'(t64det_pkg::FIFO_DEPTH);

    logic [t64det_pkg::DIM_W-1:0] width_reg;
    logic [t64det_pkg::DIM_W-1:0] height_reg;
    logic [1:0]                   format_reg;
    logic                         wide_reg;

    logic [t64det_pkg::DIM_W-1:0] width_trim;
    logic [t64det_pkg::DIM_W-1:0] height_trim;
    logic [t64det_pkg::DIM_W-1:0] eff_width;

    t64det_pkg::cfg_t             cfg;
    t64det_pkg::q_status_t        q_status;
    t64det_pkg::qentry_t          push_entry;
    t64det_pkg::qentry_t          head;
    t64det_pkg::back_status_t     back_status;
    logic                         front_push;
    logic                         back_pop;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= t64det_pkg::DIM_W'(t64det_pkg::TILE_W);
            height_reg <= t64det_pkg::DIM_W'(4);
            format_reg <= t64det_pkg::FMT_NV12;
            wide_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (t64det_pkg::reg_index_t'(cfg_index))
                t64det_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                t64det_pkg::REG_HEIGHT: height_reg <= cfg_data;
                t64det_pkg::REG_FORMAT: format_reg <= cfg_data[1:0];
                t64det_pkg::REG_WIDE:   wide_reg   <= cfg_data[0];
                default:                wide_reg   <= wide_reg;
            endcase
        end
    end

    // derive the effective frame setup: trim and clamp the dimensions
    always_comb
    begin
        width_trim  = width_reg & ~t64det_pkg::DIM_W'(t64det_pkg::TILE_W - 1);
        height_trim = height_reg & ~t64det_pkg::DIM_W'(3);
        if (width_trim < t64det_pkg::DIM_W'(t64det_pkg::TILE_W))
        begin
            eff_width = t64det_pkg::DIM_W'(t64det_pkg::TILE_W);
        end
        else if (width_trim > t64det_pkg::DIM_W'(t64det_pkg::MAX_W))
        begin
            eff_width = t64det_pkg::DIM_W'(t64det_pkg::MAX_W);
        end
        else
        begin
            eff_width = width_trim;
        end
        cfg.width = eff_width;
        if (height_trim < t64det_pkg::DIM_W'(4))
        begin
            cfg.height = t64det_pkg::DIM_W'(4);
        end
        else if (height_trim > t64det_pkg::DIM_W'(t64det_pkg::MAX_H))
        begin
            cfg.height = t64det_pkg::DIM_W'(t64det_pkg::MAX_H);
        end
        else
        begin
            cfg.height = height_trim;
        end
        cfg.tiles_per_row = t64det_pkg::TPR_W'(eff_width >> $clog2(t64det_pkg::TILE_W));
        cfg.plane_count   = (format_reg == t64det_pkg::FMT_I444) ? 2'd3 : 2'd2;
        cfg.half_chroma   = (format_reg != t64det_pkg::FMT_NV16)
                         && (format_reg != t64det_pkg::FMT_I444);
        cfg.wide          = wide_reg;
    end

    t64det_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tiled      (tiled),
        .q_status   (q_status),
        .push       (front_push),
        .push_entry (push_entry)
    );

    t64det_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_entry (push_entry),
        .pop        (back_pop),
        .pop_entry  (head),
        .status     (q_status)
    );

    t64det_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_status (q_status),
        .head     (head),
        .pop      (back_pop),
        .linear   (linear),
        .status   (back_status)
    );

    `T64DET_ASSERT_NEXT(push_fills_queue, front_push, !q_status.empty, "kept request lost")
    `T64DET_ASSERT_IMPL(queue_bounded, 1'b1, q_status.count <= QUEUE_FULL, "queue overflow")
    `T64DET_ASSERT_NEXT(stage_a_holds, back_status.a_stall, back_status.a_valid, "stalled request dropped")

endmodule
